@@ hdl/eeq_pkg.sv @@
// ----------------------------------------------------------------------------
// eeq_pkg
// Shared types and constants for the expiring entry queue.
// ----------------------------------------------------------------------------
package eeq_pkg;

  localparam int LIFE_W  = 20;
  localparam int TIME_W  = 64;
  localparam int FIELD_W = 4;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  localparam logic [LIFE_W-1:0]  DEFAULT_LIFETIME = 20'd4000;
  localparam logic [FIELD_W-1:0] DEFAULT_VISIBLE  = 4'd3;

  typedef struct packed {
    logic              req_type;
    logic [LIFE_W-1:0] lifetime_ms;
    logic [TIME_W-1:0] now_time;
  } eeq_in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] removed_count;
    logic [FIELD_W-1:0] entry_count;
    logic [FIELD_W-1:0] visible_count;
  } eeq_out_t;

  typedef struct packed {
    logic [TIME_W-1:0] created_at;
    logic [LIFE_W-1:0] lifetime;
  } eeq_entry_t;

  // per-cell control: load takes the broadcast word, shift takes the neighbor
  typedef struct packed {
    logic load;
    logic shift;
  } eeq_cell_ctl_t;

endpackage

@@ hdl/eeq_in_if.sv @@
// ----------------------------------------------------------------------------
// eeq_in_if
// Input item channel: valid/ready handshake with request payload.
// ----------------------------------------------------------------------------
interface eeq_in_if;
  import eeq_pkg::*;

  logic    valid;
  logic    ready;
  eeq_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/eeq_out_if.sv @@
// ----------------------------------------------------------------------------
// eeq_out_if
// Result channel: valid/ready handshake with count payload.
// ----------------------------------------------------------------------------
interface eeq_out_if;
  import eeq_pkg::*;

  logic     valid;
  logic     ready;
  eeq_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/eeq_cfg_if.sv @@
// ----------------------------------------------------------------------------
// eeq_cfg_if
// Configuration write channel carrying the visible limit.
// ----------------------------------------------------------------------------
interface eeq_cfg_if;
  import eeq_pkg::*;

  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/eeq_cell.sv @@
// ----------------------------------------------------------------------------
// eeq_cell
// One queue slot: holds an entry, loads the broadcast word or its neighbor.
// ----------------------------------------------------------------------------
module eeq_cell (
  input  logic                   clk,
  input  eeq_pkg::eeq_cell_ctl_t ctl,
  input  eeq_pkg::eeq_entry_t    load_data,
  input  eeq_pkg::eeq_entry_t    neigh_data,
  output eeq_pkg::eeq_entry_t    entry
);
  import eeq_pkg::*;

  eeq_entry_t entry_r;
  eeq_entry_t entry_nxt;

  always_comb begin
    if (ctl.load) begin
      entry_nxt = load_data;
    end else if (ctl.shift) begin
      entry_nxt = neigh_data;
    end else begin
      entry_nxt = entry_r;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

@@ hdl/expiring_entry_queue_unit.sv @@
// ----------------------------------------------------------------------------
// expiring_entry_queue_unit
// Insert: result registered the cycle after accept; next item taken once the result is free or read.
// Tick: head of the cell row is checked and rotated once per held entry
//   (an empty queue answers without a sweep); one age compare unit.
// Reset (sync, active low) empties the queue and sets the visible limit to 3.
// ----------------------------------------------------------------------------
module expiring_entry_queue_unit #(
  parameter int DEPTH = 8
) (
  input logic         clk,
  input logic         rst_n,
  eeq_in_if.sink      in_chan,
  eeq_out_if.source   out_chan,
  eeq_cfg_if.sink     cfg_chan
);
  import eeq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_SWEEP = 1'b1;

  logic               state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      steps_r, steps_nxt;
  logic [CW-1:0]      removed_r, removed_nxt;
  logic [TIME_W-1:0]  now_r, now_nxt;
  logic [FIELD_W-1:0] limit_r;
  logic               out_valid_r, out_valid_nxt;
  eeq_out_t           out_data_r, out_data_nxt;

  eeq_entry_t    cell_q [DEPTH];
  eeq_cell_ctl_t cell_ctl [DEPTH];
  eeq_entry_t    load_data;
  eeq_entry_t    new_entry;
  logic          shift_all;
  logic          load_en;
  logic [CW-1:0] load_pos;
  logic          in_fire;
  logic          finish;
  logic [CW-1:0] fin_removed;
  logic [CW-1:0] fin_count;
  logic [TIME_W-1:0] head_age;
  logic          head_expired;
  logic [FIELD_W-1:0] eff_limit;
  logic [CW+FIELD_W-1:0] cnt_ext, lim_ext, vis_ext, rem_ext;

  // ---- cell row ----
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    eeq_entry_t neigh;
    if (i < DEPTH - 1) begin : g_mid
      assign neigh = cell_q[i+1];
    end else begin : g_last
      assign neigh = cell_q[i];
    end
    assign cell_ctl[i].shift = shift_all;
    assign cell_ctl[i].load  = load_en && (load_pos[IW-1:0] == IW'(i));

    eeq_cell u_cell (
      .clk        (clk),
      .ctl        (cell_ctl[i]),
      .load_data  (load_data),
      .neigh_data (neigh),
      .entry      (cell_q[i])
    );
  end

  assign in_chan.ready  = (state_r == ST_IDLE) && (!out_valid_r || out_chan.ready);
  assign in_fire        = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready = 1'b1;

  assign new_entry.created_at = in_chan.data.now_time;
  assign new_entry.lifetime   = (in_chan.data.lifetime_ms == '0) ? DEFAULT_LIFETIME
                                                                 : in_chan.data.lifetime_ms;

  // age check on the head cell only; wraps modulo 2^64
  assign head_age     = now_r - cell_q[0].created_at;
  assign head_expired = head_age >= {{(TIME_W-LIFE_W){1'b0}}, cell_q[0].lifetime};

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    steps_nxt   = steps_r;
    removed_nxt = removed_r;
    now_nxt     = now_r;
    shift_all   = 1'b0;
    load_en     = 1'b0;
    load_pos    = count_r;
    load_data   = new_entry;
    finish      = 1'b0;
    fin_removed = '0;
    fin_count   = count_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_chan.data.req_type == REQ_INSERT) begin
            load_en = 1'b1;
            if (count_r == CW'(DEPTH)) begin
              // full: drop the oldest, append at the last cell
              shift_all = 1'b1;
              load_pos  = CW'(DEPTH - 1);
            end else begin
              count_nxt = count_r + CW'(1);
            end
            finish    = 1'b1;
            fin_count = count_nxt;
          end else if (count_r == '0) begin
            finish    = 1'b1;
            fin_count = '0;
          end else begin
            state_nxt   = ST_SWEEP;
            steps_nxt   = count_r;
            removed_nxt = '0;
            now_nxt     = in_chan.data.now_time;
          end
        end
      end
      ST_SWEEP: begin
        // pop the head; a survivor goes back in behind the current tail
        shift_all = 1'b1;
        if (head_expired) begin
          count_nxt   = count_r - CW'(1);
          removed_nxt = removed_r + CW'(1);
        end else begin
          load_en   = 1'b1;
          load_pos  = count_r - CW'(1);
          load_data = cell_q[0];
        end
        steps_nxt = steps_r - CW'(1);
        if (steps_r == CW'(1)) begin
          finish      = 1'b1;
          fin_removed = removed_nxt;
          fin_count   = count_nxt;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // result formatting: compare at full count width, then keep the low 4 bits
  assign eff_limit = (limit_r == '0) ? DEFAULT_VISIBLE : limit_r;
  assign cnt_ext   = {{FIELD_W{1'b0}}, fin_count};
  assign rem_ext   = {{FIELD_W{1'b0}}, fin_removed};
  assign lim_ext   = {{CW{1'b0}}, eff_limit};
  assign vis_ext   = (cnt_ext < lim_ext) ? cnt_ext : lim_ext;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (finish) begin
      out_valid_nxt              = 1'b1;
      out_data_nxt.removed_count = rem_ext[FIELD_W-1:0];
      out_data_nxt.entry_count   = cnt_ext[FIELD_W-1:0];
      out_data_nxt.visible_count = vis_ext[FIELD_W-1:0];
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      steps_r     <= '0;
      removed_r   <= '0;
      limit_r     <= DEFAULT_VISIBLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      steps_r     <= steps_nxt;
      removed_r   <= removed_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_chan.valid) begin
        limit_r <= cfg_chan.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    now_r      <= now_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  // ---- checks ----
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above depth");

  a_sweep_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SWEEP |-> !out_valid_r)
    else $error("result register busy during sweep");

  a_sweep_steps: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SWEEP |-> (steps_r != '0) && (steps_r <= count_r))
    else $error("sweep step count out of range");

  a_sweep_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP) && (steps_r == CW'(1)) |=> out_valid_r && (state_r == ST_IDLE))
    else $error("sweep end did not post a result");

endmodule
